### sv/selective_repeat_sender_window_defines.svh
// assertion macros used by the sender window controller
`ifndef SELECTIVE_REPEAT_SENDER_WINDOW_DEFINES_SVH
`define SELECTIVE_REPEAT_SENDER_WINDOW_DEFINES_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication
`define SRSW_ASSERT(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("srsw assertion failed");
// next-cycle implication
`define SRSW_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("srsw assertion failed");
`else
`define SRSW_ASSERT(lbl, ck, rn, ante, cons)
`define SRSW_ASSERT_NEXT(lbl, ck, rn, ante, cons)
`endif

`endif

### sv/srsw_pkg.sv
package srsw_pkg;

    // parameter defaults
    localparam int WINDOW_DEF       = 8;
    localparam int SEQ_BITS_DEF     = 8;
    localparam int PAYLOAD_BITS_DEF = 64;

    // fixed field widths on the ports
    localparam int OP_W    = 2;
    localparam int SEQ_W   = 8;
    localparam int PAY_W   = 64;
    localparam int EV_W    = 3;
    localparam int TDATA_W = 80;

    // opcodes
    localparam logic [OP_W-1:0] OP_SEND    = 2'd0;
    localparam logic [OP_W-1:0] OP_ACK     = 2'd1;
    localparam logic [OP_W-1:0] OP_TIMEOUT = 2'd2;

    typedef enum logic [EV_W-1:0] {
        EV_SENT    = 3'd0,
        EV_REFUSED = 3'd1,
        EV_ACKED   = 3'd2,
        EV_DISCARD = 3'd3,
        EV_RESENT  = 3'd4
    } event_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SLIDE
    } state_t;

    typedef struct packed {
        event_t              event_res;
        logic [SEQ_W-1:0]    packet_sequence;
        logic [PAY_W-1:0]    packet_payload;
        logic                window_full;
    } result_t;

endpackage

### sv/selective_repeat_sender_window.sv
// Sender side of a selective-repeat ARQ link. Each input transaction carries one
// event in s_axis_tuser (send a new payload, an ack arrived, or a retransmit timer
// expired) and yields exactly one result transaction telling what happened: packet
// sent, send refused because the window is full, ack accepted, input discarded, or
// packet resent with its buffered payload. Unacknowledged payloads live in a
// WINDOW-deep circular payload memory addressed by slot; per-slot acknowledged bits
// sit in flip-flops cleared by reset. Sequence numbers wrap at 2^SEQ_BITS and the
// usable window is WINDOW, capped at 2^SEQ_BITS - 1. Items are handled one at a
// time: sends, timeouts and discards are accepted in IDLE, which launches the
// payload memory read, then executed in EXEC, which uses the read data; an accepted
// ack moves on to SLIDE, where the window base advances one slot per cycle past
// acknowledged slots, and is reported once the base stops. A new transaction is
// taken while the previous result still waits in the output register; execution
// stalls only when that register is still occupied.
module selective_repeat_sender_window #(
    parameter int WINDOW       = srsw_pkg::WINDOW_DEF,
    parameter int SEQ_BITS     = srsw_pkg::SEQ_BITS_DEF,
    parameter int PAYLOAD_BITS = srsw_pkg::PAYLOAD_BITS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // payload_word [63:0], sequence_number [71:64], checksum_ok [72], zero fill
    input  logic [srsw_pkg::TDATA_W-1:0]     s_axis_tdata,
    // opcode [1:0]
    input  logic [srsw_pkg::OP_W-1:0]        s_axis_tuser,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // packet_sequence [7:0], packet_payload [71:8], window_full [72], zero fill
    output logic [srsw_pkg::TDATA_W-1:0]     m_axis_tdata,
    // event_res [2:0]
    output logic [srsw_pkg::EV_W-1:0]        m_axis_tuser
);

    localparam int ADDR_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;

    // payload memory port
    logic                    mem_we;
    logic [ADDR_W-1:0]       mem_waddr;
    logic [PAYLOAD_BITS-1:0] mem_wdata;
    logic                    mem_re;
    logic [ADDR_W-1:0]       mem_raddr;
    logic [PAYLOAD_BITS-1:0] mem_rdata;

    // result handoff into the output register
    logic                    res_valid;
    srsw_pkg::result_t       res;
    logic                    out_free;

    logic                    out_valid_reg, out_valid_next;
    srsw_pkg::result_t       out_res_reg;

    // output register is free when empty or drained this cycle
    assign out_free = !out_valid_reg || m_axis_tready;

    srsw_window_ctrl #(
        .WINDOW       (WINDOW),
        .SEQ_BITS     (SEQ_BITS),
        .PAYLOAD_BITS (PAYLOAD_BITS),
        .ADDR_W       (ADDR_W)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_opcode  (s_axis_tuser),
        .in_payload (s_axis_tdata[63:0]),
        .in_seq     (s_axis_tdata[71:64]),
        .in_ok      (s_axis_tdata[72]),
        .out_free   (out_free),
        .res_valid  (res_valid),
        .res        (res),
        .mem_we     (mem_we),
        .mem_waddr  (mem_waddr),
        .mem_wdata  (mem_wdata),
        .mem_re     (mem_re),
        .mem_raddr  (mem_raddr),
        .mem_rdata  (mem_rdata)
    );

    srsw_payload_mem #(
        .DEPTH  (WINDOW),
        .ADDR_W (ADDR_W),
        .DATA_W (PAYLOAD_BITS)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // output register: load a fresh result, else drop once taken
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (res_valid)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid)
        begin
            out_res_reg <= res;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_res_reg.event_res;
    assign m_axis_tdata  = {7'b0, out_res_reg.window_full, out_res_reg.packet_payload,
                            out_res_reg.packet_sequence};

endmodule

### sv/srsw_payload_mem.sv
module srsw_payload_mem #(
    parameter int DEPTH  = srsw_pkg::WINDOW_DEF,
    parameter int ADDR_W = 3,
    parameter int DATA_W = srsw_pkg::PAYLOAD_BITS_DEF
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // read data holds until the next read
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

### sv/srsw_window_ctrl.sv
`include "selective_repeat_sender_window_defines.svh"

module srsw_window_ctrl #(
    parameter int WINDOW       = srsw_pkg::WINDOW_DEF,
    parameter int SEQ_BITS     = srsw_pkg::SEQ_BITS_DEF,
    parameter int PAYLOAD_BITS = srsw_pkg::PAYLOAD_BITS_DEF,
    parameter int ADDR_W       = 3
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [srsw_pkg::OP_W-1:0]       in_opcode,
    input  logic [srsw_pkg::PAY_W-1:0]      in_payload,
    input  logic [srsw_pkg::SEQ_W-1:0]      in_seq,
    input  logic                            in_ok,
    input  logic                            out_free,
    output logic                            res_valid,
    output srsw_pkg::result_t               res,
    output logic                            mem_we,
    output logic [ADDR_W-1:0]               mem_waddr,
    output logic [PAYLOAD_BITS-1:0]         mem_wdata,
    output logic                            mem_re,
    output logic [ADDR_W-1:0]               mem_raddr,
    input  logic [PAYLOAD_BITS-1:0]         mem_rdata
);

    localparam int EFF_WIN = (WINDOW < (2 ** SEQ_BITS)) ? WINDOW : (2 ** SEQ_BITS) - 1;
    localparam int OFF_W   = (SEQ_BITS > ADDR_W) ? SEQ_BITS : ADDR_W;
    localparam logic [ADDR_W-1:0] LAST_SLOT = ADDR_W'(WINDOW - 1);
    localparam logic [ADDR_W:0]   WIN_SUM   = (ADDR_W + 1)'(WINDOW);

    srsw_pkg::state_t state_reg, state_next;

    logic [SEQ_BITS-1:0]     base_reg, base_next;
    logic [SEQ_BITS-1:0]     next_seq_reg, next_seq_next;
    logic [ADDR_W-1:0]       base_slot_reg, base_slot_next;
    logic [ADDR_W-1:0]       tail_slot_reg, tail_slot_next;
    logic [WINDOW-1:0]       acked_reg, acked_next;

    // held transaction
    logic [srsw_pkg::OP_W-1:0] op_reg;
    logic [PAYLOAD_BITS-1:0]   pay_reg;
    logic [SEQ_BITS-1:0]       seq_reg;
    logic                      ok_reg;
    logic [ADDR_W-1:0]         slot_reg;

    logic                      accept;
    logic [SEQ_BITS-1:0]       seq_in;
    logic [SEQ_BITS-1:0]       off_in;
    logic [OFF_W-1:0]          off_in_ext;
    logic [ADDR_W-1:0]         slot_in;
    logic [SEQ_BITS-1:0]       count;
    logic [SEQ_BITS-1:0]       off;
    logic                      in_win;
    logic                      full_now;
    logic                      full_after_send;
    logic                      do_send;
    logic                      ack_ok;
    logic                      resend_ok;
    logic                      slide_step;

    function automatic logic [ADDR_W-1:0] slot_add(input logic [ADDR_W-1:0] a,
                                                    input logic [ADDR_W-1:0] b);
        logic [ADDR_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= WIN_SUM)
        begin
            s = s - WIN_SUM;
        end
        return s[ADDR_W-1:0];
    endfunction

    function automatic logic [ADDR_W-1:0] slot_inc(input logic [ADDR_W-1:0] a);
        return (a == LAST_SLOT) ? '0 : a + 1'b1;
    endfunction

    // slot lookup for the incoming transaction, feeds the memory read
    assign accept     = in_valid && in_ready;
    assign seq_in     = SEQ_BITS'(in_seq);
    assign off_in     = seq_in - base_reg;
    assign off_in_ext = OFF_W'(off_in);
    assign slot_in    = (int'(off_in) < WINDOW) ?
                        slot_add(base_slot_reg, off_in_ext[ADDR_W-1:0]) : '0;

    // window decisions on the held transaction
    assign count           = next_seq_reg - base_reg;
    assign off             = seq_reg - base_reg;
    assign in_win          = off < count;
    assign full_now        = int'(count) >= EFF_WIN;
    assign full_after_send = (int'(count) + 1) >= EFF_WIN;
    assign do_send         = (op_reg == srsw_pkg::OP_SEND) && !full_now;
    assign ack_ok          = (op_reg == srsw_pkg::OP_ACK) && ok_reg && in_win;
    assign resend_ok       = (op_reg == srsw_pkg::OP_TIMEOUT) && in_win && !acked_reg[slot_reg];
    assign slide_step      = acked_reg[base_slot_reg] && (count != '0);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            srsw_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = srsw_pkg::ST_EXEC;
                end
            end
            srsw_pkg::ST_EXEC:
            begin
                if (out_free)
                begin
                    state_next = ack_ok ? srsw_pkg::ST_SLIDE : srsw_pkg::ST_IDLE;
                end
            end
            srsw_pkg::ST_SLIDE:
            begin
                if (!slide_step && out_free)
                begin
                    state_next = srsw_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = srsw_pkg::ST_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        in_ready                = 1'b0;
        res_valid               = 1'b0;
        res.event_res           = srsw_pkg::EV_DISCARD;
        res.packet_sequence     = '0;
        res.packet_payload      = '0;
        res.window_full         = full_now;
        mem_we                  = 1'b0;
        mem_waddr               = tail_slot_reg;
        mem_wdata               = pay_reg;
        mem_re                  = 1'b0;
        mem_raddr               = slot_in;
        unique case (state_reg)
            srsw_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                mem_re   = in_valid;
            end
            srsw_pkg::ST_EXEC:
            begin
                if (out_free && !ack_ok)
                begin
                    res_valid = 1'b1;
                    priority if (op_reg == srsw_pkg::OP_SEND)
                    begin
                        if (do_send)
                        begin
                            mem_we              = 1'b1;
                            res.event_res       = srsw_pkg::EV_SENT;
                            res.packet_sequence = srsw_pkg::SEQ_W'(next_seq_reg);
                            res.packet_payload  = srsw_pkg::PAY_W'(pay_reg);
                            res.window_full     = full_after_send;
                        end
                        else
                        begin
                            res.event_res = srsw_pkg::EV_REFUSED;
                        end
                    end
                    else if (resend_ok)
                    begin
                        res.event_res       = srsw_pkg::EV_RESENT;
                        res.packet_sequence = srsw_pkg::SEQ_W'(seq_reg);
                        res.packet_payload  = srsw_pkg::PAY_W'(mem_rdata);
                    end
                    else
                    begin
                        res.event_res = srsw_pkg::EV_DISCARD;
                    end
                end
            end
            srsw_pkg::ST_SLIDE:
            begin
                if (!slide_step && out_free)
                begin
                    res_valid           = 1'b1;
                    res.event_res       = srsw_pkg::EV_ACKED;
                    res.packet_sequence = srsw_pkg::SEQ_W'(seq_reg);
                end
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    // window state updates
    always_comb
    begin
        base_next      = base_reg;
        next_seq_next  = next_seq_reg;
        base_slot_next = base_slot_reg;
        tail_slot_next = tail_slot_reg;
        acked_next     = acked_reg;
        if ((state_reg == srsw_pkg::ST_EXEC) && out_free)
        begin
            if (do_send)
            begin
                acked_next[tail_slot_reg] = 1'b0;
                next_seq_next             = next_seq_reg + 1'b1;
                tail_slot_next            = slot_inc(tail_slot_reg);
            end
            if (ack_ok)
            begin
                acked_next[slot_reg] = 1'b1;
            end
        end
        if ((state_reg == srsw_pkg::ST_SLIDE) && slide_step)
        begin
            acked_next[base_slot_reg] = 1'b0;
            base_next                 = base_reg + 1'b1;
            base_slot_next            = slot_inc(base_slot_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= srsw_pkg::ST_IDLE;
            base_reg      <= '0;
            next_seq_reg  <= '0;
            base_slot_reg <= '0;
            tail_slot_reg <= '0;
            acked_reg     <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            base_reg      <= base_next;
            next_seq_reg  <= next_seq_next;
            base_slot_reg <= base_slot_next;
            tail_slot_reg <= tail_slot_next;
            acked_reg     <= acked_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg   <= in_opcode;
            pay_reg  <= in_payload[PAYLOAD_BITS-1:0];
            seq_reg  <= seq_in;
            ok_reg   <= in_ok;
            slot_reg <= slot_in;
        end
    end

    `SRSW_ASSERT(a_idle_settled, clk, rst_n, state_reg == srsw_pkg::ST_IDLE, !slide_step)
    `SRSW_ASSERT(a_count_bound, clk, rst_n, 1'b1, int'(count) <= EFF_WIN)
    `SRSW_ASSERT(a_empty_slots, clk, rst_n, count == '0, tail_slot_reg == base_slot_reg)
    `SRSW_ASSERT(a_emit_free, clk, rst_n, res_valid, out_free)
    `SRSW_ASSERT_NEXT(a_accept_exec, clk, rst_n, accept, state_reg == srsw_pkg::ST_EXEC)

endmodule

### verif/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import srsw_pkg::*;

    // opcode 3 is not defined by the block and must be discarded
    localparam logic [OP_W-1:0] OP_UNKNOWN = 2'd3;

    localparam int SEQ_SPACE = 1 << SEQ_BITS_DEF;
    localparam int WIN_SLOTS = WINDOW_DEF;
    localparam int SLOT_W    = (WIN_SLOTS > 1) ? $clog2(WIN_SLOTS) : 1;
    // usable window, capped so that a full window never looks empty
    localparam int EFF_WIN = (WINDOW_DEF < SEQ_SPACE) ? WINDOW_DEF : SEQ_SPACE - 1;

    localparam int RANDOM_ITEMS = 627;
    localparam int IDLE_LIMIT   = 2000;
    localparam int TAIL_CYCLES  = 30;

    typedef struct {
        logic [OP_W-1:0]  op;
        logic [PAY_W-1:0] pay;
        logic [SEQ_W-1:0] seq;
        logic             ok;
        bit               has_typed;
        result_t          res;
    } step_row_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    logic [TDATA_W-1:0]  s_axis_tdata = '0;
    logic [OP_W-1:0]     s_axis_tuser = '0;
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    logic [TDATA_W-1:0]  m_axis_tdata;
    logic [EV_W-1:0]     m_axis_tuser;

    // predictor state: oldest unacked number, next number, per-slot acked bits, payloads
    logic [SEQ_W-1:0]    pred_base = '0;
    logic [SEQ_W-1:0]    pred_next = '0;
    logic [WIN_SLOTS-1:0] pred_acked = '0;
    logic [PAY_W-1:0]    pred_payloads [WIN_SLOTS];

    result_t             expected_events [$];
    step_row_t           directed_steps [$];
    int                  error_count = 0;
    int                  idle_cycles = 0;
    int                  cycle_count = 0;
    int                  rx_hold = 0;
    bit                  tx_calm = 1'b0;

    always #10 clk = ~clk;

    selective_repeat_sender_window dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // mostly short gaps, a few long ones, none in calm stretches
    function automatic int pick_idle(input bit calm);
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 50)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    // advances the sender window by one event and returns the packet it reports
    function automatic result_t predict_sender_event(input logic [OP_W-1:0] op,
                                                     input logic [PAY_W-1:0] pay,
                                                     input logic [SEQ_W-1:0] seq,
                                                     input logic ok);
        logic [SEQ_W-1:0] count;
        logic [SEQ_W-1:0] off;
        logic [SEQ_W-1:0] left;
        result_t          r;
        count = pred_next - pred_base;
        off   = seq - pred_base;
        r.event_res       = EV_DISCARD;
        r.packet_sequence = '0;
        r.packet_payload  = '0;
        case (op)
            OP_SEND:
            begin
                if (count >= EFF_WIN)
                begin
                    r.event_res = EV_REFUSED;
                end
                else
                begin
                    pred_payloads[count[SLOT_W-1:0]] = pay;
                    pred_acked[count[SLOT_W-1:0]] = 1'b0;
                    r.event_res       = EV_SENT;
                    r.packet_sequence = pred_next;
                    r.packet_payload  = pay;
                    pred_next = pred_next + 1'b1;
                end
            end
            OP_ACK:
            begin
                if (ok && off < count)
                begin
                    pred_acked[off[SLOT_W-1:0]] = 1'b1;
                    r.event_res       = EV_ACKED;
                    r.packet_sequence = seq;
                    // slide past every acked slot at the front
                    while (pred_acked[0] && pred_next != pred_base)
                    begin
                        pred_acked = pred_acked >> 1;
                        for (int i = 0; i < WIN_SLOTS - 1; i++)
                            pred_payloads[i] = pred_payloads[i + 1];
                        pred_payloads[WIN_SLOTS - 1] = '0;
                        pred_base = pred_base + 1'b1;
                    end
                end
            end
            OP_TIMEOUT:
            begin
                if (off < count && !pred_acked[off[SLOT_W-1:0]])
                begin
                    r.event_res       = EV_RESENT;
                    r.packet_sequence = seq;
                    r.packet_payload  = pred_payloads[off[SLOT_W-1:0]];
                end
            end
            default:
            begin
            end
        endcase
        left = pred_next - pred_base;
        r.window_full = (left >= EFF_WIN);
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        error_count++;
        $display("mismatch at %0t: %s", $time, msg);
    endtask

    task automatic add_row(input logic [OP_W-1:0] op, input logic [PAY_W-1:0] pay,
                           input logic [SEQ_W-1:0] seq, input logic ok, input bit typed,
                           input event_t ev, input logic [SEQ_W-1:0] pseq,
                           input logic [PAY_W-1:0] ppay, input logic full);
        step_row_t row;
        row.op = op;
        row.pay = pay;
        row.seq = seq;
        row.ok = ok;
        row.has_typed = typed;
        row.res.event_res = ev;
        row.res.packet_sequence = pseq;
        row.res.packet_payload = ppay;
        row.res.window_full = full;
        directed_steps.push_back(row);
    endtask

    // one input transaction; called at a rising edge, returns at the accepting edge
    task automatic drive_event(input logic [OP_W-1:0] op, input logic [PAY_W-1:0] pay,
                               input logic [SEQ_W-1:0] seq, input logic ok,
                               input bit has_typed, input result_t typed_res);
        int      gap;
        result_t predicted;
        gap = pick_idle(tx_calm);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {{(TDATA_W - PAY_W - SEQ_W - 1){1'b0}}, ok, seq, pay};
        do
            @(posedge clk);
        while (!s_axis_tready);
        predicted = predict_sender_event(op, pay, seq, ok);
        expected_events.push_back(has_typed ? typed_res : predicted);
    endtask

    // receiver side: random stalls, with calm stretches of constant ready
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (rx_hold > 0)
        begin
            m_axis_tready <= 1'b0;
            rx_hold <= rx_hold - 1;
        end
        else
        begin
            m_axis_tready <= 1'b1;
            rx_hold <= pick_idle((cycle_count % 1000) >= 750);
        end
    end

    // result checker: every packet transaction is compared with the oldest expectation
    always @(posedge clk)
    begin
        result_t exp_res;
        if (m_axis_tvalid && m_axis_tready)
        begin
            if (expected_events.size() == 0)
            begin
                report_mismatch($sformatf("unexpected result, event %0d seq %0d",
                                          m_axis_tuser, m_axis_tdata[7:0]));
            end
            else
            begin
                exp_res = expected_events.pop_front();
                if (m_axis_tuser !== exp_res.event_res)
                    report_mismatch($sformatf("event_res got %0d want %0d",
                                              m_axis_tuser, exp_res.event_res));
                if (m_axis_tdata[SEQ_W-1:0] !== exp_res.packet_sequence)
                    report_mismatch($sformatf("packet_sequence got %0d want %0d",
                                              m_axis_tdata[SEQ_W-1:0],
                                              exp_res.packet_sequence));
                if (m_axis_tdata[SEQ_W+PAY_W-1:SEQ_W] !== exp_res.packet_payload)
                    report_mismatch($sformatf("packet_payload got %h want %h",
                                              m_axis_tdata[SEQ_W+PAY_W-1:SEQ_W],
                                              exp_res.packet_payload));
                if (m_axis_tdata[SEQ_W+PAY_W] !== exp_res.window_full)
                    report_mismatch($sformatf("window_full got %b want %b",
                                              m_axis_tdata[SEQ_W+PAY_W],
                                              exp_res.window_full));
            end
        end
    end

    // watchdog on cycles with no transaction on either side
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("** selective_repeat_sender_window: FAILED **");
            $finish;
        end
    end

    initial
    begin
        logic [PAY_W-1:0] pay;
        logic [SEQ_W-1:0] seq;
        logic [SEQ_W-1:0] count;
        logic [OP_W-1:0]  op;
        logic             ok;
        result_t          no_res;
        int               used;
        int               pick;

        no_res = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // nothing outstanding: acks, timeouts and unknown opcodes are dropped
        add_row(OP_ACK, '0, 8'd0, 1'b1, 1, EV_DISCARD, 8'd0, '0, 1'b0);
        add_row(OP_TIMEOUT, '0, 8'd0, 1'b1, 1, EV_DISCARD, 8'd0, '0, 1'b0);
        add_row(OP_UNKNOWN, '1, 8'hFF, 1'b1, 1, EV_DISCARD, 8'd0, '0, 1'b0);
        // fill the window, payload extremes, full flag on the last send
        add_row(OP_SEND, '0, 8'd0, 1'b0, 1, EV_SENT, 8'd0, '0, 1'b0);
        add_row(OP_SEND, '1, 8'd0, 1'b0, 1, EV_SENT, 8'd1, '1, 1'b0);
        add_row(OP_SEND, 64'hA5A5_A5A5_A5A5_A5A5, 8'd0, 1'b0, 1,
                EV_SENT, 8'd2, 64'hA5A5_A5A5_A5A5_A5A5, 1'b0);
        add_row(OP_SEND, 64'h5A5A_5A5A_5A5A_5A5A, 8'd0, 1'b0, 1,
                EV_SENT, 8'd3, 64'h5A5A_5A5A_5A5A_5A5A, 1'b0);
        add_row(OP_SEND, 64'h0123_4567_89AB_CDEF, 8'd0, 1'b0, 1,
                EV_SENT, 8'd4, 64'h0123_4567_89AB_CDEF, 1'b0);
        add_row(OP_SEND, 64'hFEDC_BA98_7654_3210, 8'd0, 1'b0, 1,
                EV_SENT, 8'd5, 64'hFEDC_BA98_7654_3210, 1'b0);
        add_row(OP_SEND, 64'h8000_0000_0000_0001, 8'd0, 1'b0, 1,
                EV_SENT, 8'd6, 64'h8000_0000_0000_0001, 1'b0);
        add_row(OP_SEND, 64'h7FFF_FFFF_FFFF_FFFE, 8'd0, 1'b0, 1,
                EV_SENT, 8'd7, 64'h7FFF_FFFF_FFFF_FFFE, 1'b1);
        // full window refuses, bad checksum drops
        add_row(OP_SEND, 64'h1111_2222_3333_4444, 8'd0, 1'b0, 1,
                EV_REFUSED, 8'd0, '0, 1'b1);
        add_row(OP_ACK, '0, 8'd0, 1'b0, 1, EV_DISCARD, 8'd0, '0, 1'b1);
        // resend, ack out of order, timeout of acked slot, repeated ack
        add_row(OP_TIMEOUT, '0, 8'd3, 1'b0, 0, EV_DISCARD, 8'd0, '0, 1'b0);
        add_row(OP_ACK, '0, 8'd3, 1'b1, 0, EV_DISCARD, 8'd0, '0, 1'b0);
        add_row(OP_TIMEOUT, '0, 8'd3, 1'b1, 0, EV_DISCARD, 8'd0, '0, 1'b0);
        add_row(OP_ACK, '0, 8'd3, 1'b1, 0, EV_DISCARD, 8'd0, '0, 1'b0);
        // numbers just past the window and just before it
        add_row(OP_ACK, '0, 8'd8, 1'b1, 0, EV_DISCARD, 8'd0, '0, 1'b0);
        add_row(OP_ACK, '0, 8'hFF, 1'b1, 0, EV_DISCARD, 8'd0, '0, 1'b0);
        // base slides by one twice, then past the acked slot three
        add_row(OP_ACK, '0, 8'd0, 1'b1, 0, EV_DISCARD, 8'd0, '0, 1'b0);
        add_row(OP_ACK, '0, 8'd1, 1'b1, 0, EV_DISCARD, 8'd0, '0, 1'b0);
        add_row(OP_ACK, '0, 8'd2, 1'b1, 0, EV_DISCARD, 8'd0, '0, 1'b0);
        add_row(OP_TIMEOUT, '0, 8'd7, 1'b0, 0, EV_DISCARD, 8'd0, '0, 1'b0);
        add_row(OP_TIMEOUT, '1, 8'd200, 1'b0, 0, EV_DISCARD, 8'd0, '0, 1'b0);

        foreach (directed_steps[i])
            drive_event(directed_steps[i].op, directed_steps[i].pay, directed_steps[i].seq,
                        directed_steps[i].ok, directed_steps[i].has_typed,
                        directed_steps[i].res);

        // random part: mostly in-window traffic, some near misses and noise
        used = 0;
        while (used < RANDOM_ITEMS)
        begin
            tx_calm = ((used / 50) % 4) == 3;
            count = pred_next - pred_base;
            pay = {$urandom, $urandom};
            pick = $urandom_range(0, 9);
            if (pick == 0)
                pay = '0;
            else if (pick == 1)
                pay = '1;
            ok = ($urandom_range(0, 9) != 0);
            seq = SEQ_W'($urandom_range(0, 255));
            pick = $urandom_range(0, 99);
            if (pick < 42)
            begin
                op = OP_SEND;
            end
            else if (pick < 72)
            begin
                op = OP_ACK;
                seq = SEQ_W'(pred_base + ((count == 0) ? $urandom_range(0, 3)
                                                       : $urandom_range(0, count - 1)));
            end
            else if (pick < 84)
            begin
                op = OP_TIMEOUT;
                seq = SEQ_W'(pred_base + ((count == 0) ? $urandom_range(0, 3)
                                                       : $urandom_range(0, count - 1)));
            end
            else if (pick < 91)
            begin
                op = ($urandom_range(0, 1) != 0) ? OP_ACK : OP_TIMEOUT;
                seq = SEQ_W'(pred_base + $urandom_range(0, 15) - 2);
            end
            else if (pick < 97)
            begin
                op = ($urandom_range(0, 1) != 0) ? OP_ACK : OP_TIMEOUT;
            end
            else
            begin
                op = OP_UNKNOWN;
            end
            used++;
            drive_event(op, pay, seq, ok, 0, no_res);
        end
        s_axis_tvalid <= 1'b0;

        while (expected_events.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (error_count == 0)
            $display("** selective_repeat_sender_window: PASSED **");
        else
            $display("** selective_repeat_sender_window: FAILED **");
        $finish;
    end

endmodule

### sim.f
+incdir+sv
sv/srsw_pkg.sv
sv/srsw_payload_mem.sv
sv/srsw_window_ctrl.sv
sv/selective_repeat_sender_window.sv
verif/tb_top.sv
